>>> hdl/mmws_pkg.sv
// Package for the multichannel moving window sum: sizes, types, the
// slot-to-channel map and history addressing. No dependencies.
package mmws_pkg;

    localparam int NUM_CHANNELS   = 13;
    localparam int WINDOW_DEPTH   = 128;
    localparam int SAMPLE_BITS    = 10;

    localparam int SLOT_BITS      = 4;
    localparam int CH_BITS        = 4;
    localparam int SUM_BITS       = 17;
    localparam int POS_BITS       = $clog2(WINDOW_DEPTH);
    localparam int HIST_DEPTH     = NUM_CHANNELS * WINDOW_DEPTH;
    localparam int HIST_ADDR_BITS = $clog2(HIST_DEPTH);
    localparam int LAST_SLOT      = NUM_CHANNELS - 1;
    localparam int MAX_SUM        = WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1);

    typedef logic [SLOT_BITS-1:0]      t_slot;
    typedef logic [CH_BITS-1:0]        t_chan;
    typedef logic [SAMPLE_BITS-1:0]    t_sample;
    typedef logic [SUM_BITS-1:0]       t_sum;
    typedef logic [POS_BITS-1:0]       t_pos;
    typedef logic [HIST_ADDR_BITS-1:0] t_haddr;

    // history write port
    typedef struct packed {
        logic    en;
        t_haddr  addr;
        t_sample data;
    } t_hist_wr;

    // fixed scan order; unused slots map to themselves and fail the range check
    function automatic t_chan slot_to_channel(t_slot slot);
        t_chan ch;
        unique case (slot)
            4'd0:    ch = t_chan'(12);
            4'd1:    ch = t_chan'(0);
            4'd2:    ch = t_chan'(2);
            4'd3:    ch = t_chan'(1);
            4'd4:    ch = t_chan'(3);
            4'd5:    ch = t_chan'(10);
            4'd6:    ch = t_chan'(7);
            4'd7:    ch = t_chan'(11);
            4'd8:    ch = t_chan'(4);
            4'd9:    ch = t_chan'(8);
            4'd10:   ch = t_chan'(5);
            4'd11:   ch = t_chan'(9);
            4'd12:   ch = t_chan'(6);
            default: ch = t_chan'(slot);
        endcase
        return ch;
    endfunction

    function automatic t_haddr hist_addr(t_chan ch, t_pos pos);
        return t_haddr'(int'(ch) * WINDOW_DEPTH + int'(pos));
    endfunction

endpackage

>>> hdl/mmws_history.sv
// Sample history memory, one row of WINDOW_DEPTH entries per channel,
// with a zeroing sweep after reset. Depends on mmws_pkg.
module mmws_history
    import mmws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_rd_en,
    input  t_haddr   i_rd_addr,
    output t_sample  o_rd_data,
    input  t_hist_wr i_wr,
    output logic     o_clearing
);

    t_sample r_mem [HIST_DEPTH];
    t_sample r_rd_data;
    t_haddr  r_clr_addr;
    logic    r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == t_haddr'(HIST_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + t_haddr'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

>>> hdl/multichannel_moving_window_sum.sv
// Top level of the multichannel moving window sum: slot mapping, running
// sums and result register. Depends on mmws_pkg and mmws_history.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | i_valid / o_stall  | i_scan_slot, i_sample
//  result  | o_valid / i_stall  | o_channel, o_window_sum, o_end_of_scan
//
// One beat per cycle sustained while neither o_stall nor i_stall is high; a result
// is registered in the history read register, then in the result register.
// After reset the history memory is zeroed one entry a cycle, all NUM_CHANNELS *
// WINDOW_DEPTH = 1664 entries, and o_stall is high until the sweep ends.
// Beats with a slot outside the scan are taken and dropped without a result.
// A stall on the result side holds the result and the beat behind it.
module multichannel_moving_window_sum
    import mmws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SLOT_BITS-1:0] i_scan_slot,
    input  logic [9:0]           i_sample,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CH_BITS-1:0]   o_channel,
    output logic [SUM_BITS-1:0]  o_window_sum,
    output logic                 o_end_of_scan
);

    logic     clearing;
    logic     accept;
    logic     s1_adv;
    t_chan    in_ch;
    logic     in_ok;
    t_haddr   rd_addr;
    logic     rd_en;
    t_sample  rd_data;
    t_sample  old_smp;
    t_hist_wr wr;
    logic [SUM_BITS+1:0] diff;
    t_sum     n_sum;

    t_pos     r_pos;
    t_sum     r_sum [NUM_CHANNELS];

    logic     r_s1_valid;
    t_chan    r_s1_ch;
    t_sample  r_s1_smp;
    t_haddr   r_s1_addr;
    logic     r_s1_last;
    logic     r_s1_fwd;
    t_sample  r_s1_fwd_data;

    logic     r_out_valid;
    t_chan    r_out_ch;
    t_sum     r_out_sum;
    logic     r_out_last;

    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = clearing || (r_s1_valid && !s1_adv);
    assign accept  = i_valid && !o_stall;

    assign in_ch   = slot_to_channel(i_scan_slot);
    assign in_ok   = (int'(i_scan_slot) < NUM_CHANNELS) && (int'(in_ch) < NUM_CHANNELS);
    assign rd_addr = hist_addr(in_ch, r_pos);
    assign rd_en   = accept && in_ok;

    mmws_history u_history (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .i_wr       (wr),
        .o_clearing (clearing)
    );

    // the write of the beat ahead lands at the same edge as this read
    assign old_smp = r_s1_fwd ? r_s1_fwd_data : rd_data;

    always_comb begin
        diff = {2'b00, r_sum[r_s1_ch]} + (SUM_BITS + 2)'(r_s1_smp)
             - (SUM_BITS + 2)'(old_smp);
        n_sum = diff[SUM_BITS+1] ? '0 : diff[SUM_BITS-1:0];
        wr.en   = r_s1_valid && s1_adv;
        wr.addr = r_s1_addr;
        wr.data = r_s1_smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_s1_valid <= in_ok;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (wr.en) begin
                r_sum[r_s1_ch] <= n_sum;
            end
            if (rd_en && int'(i_scan_slot) == LAST_SLOT) begin
                r_pos <= (r_pos == t_pos'(WINDOW_DEPTH - 1)) ? '0 : r_pos + t_pos'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch       <= in_ch;
            r_s1_smp      <= i_sample[SAMPLE_BITS-1:0];
            r_s1_addr     <= rd_addr;
            r_s1_last     <= int'(i_scan_slot) == LAST_SLOT;
            r_s1_fwd      <= wr.en && (r_s1_addr == rd_addr);
            r_s1_fwd_data <= r_s1_smp;
        end
        if (wr.en) begin
            r_out_ch   <= r_s1_ch;
            r_out_sum  <= n_sum;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_channel     = r_out_ch;
    assign o_window_sum  = r_out_sum;
    assign o_end_of_scan = r_out_last;

`ifndef ASSERT_OFF
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> o_stall)
        else $error("beat accepted during history clear");

    a_result_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |=> (o_valid && o_channel == $past(r_s1_ch)))
        else $error("history write without a matching result");

    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pos) < WINDOW_DEPTH)
        else $error("window position out of range");

    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'(o_window_sum) <= MAX_SUM)
        else $error("window sum exceeds full-scale window");

    a_fwd_only_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && rd_en && wr.en && r_s1_addr == rd_addr) |=> r_s1_fwd)
        else $error("missed history forwarding");
`endif

endmodule

>>> bench/mmws_sum_checker.sv
`timescale 1ns / 100ps
// Result checker for multichannel_moving_window_sum. It watches both beat channels,
// keeps its own per-channel window histories and sums, and compares each result.
// Depends on mmws_pkg.
module mmws_sum_checker
    import mmws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  t_slot   i_in_slot,
    input  t_sample i_in_sample,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_chan   i_out_channel,
    input  t_sum    i_out_sum,
    input  logic    i_out_eos,
    output int      o_error_count,
    output int      o_pending
);

    typedef struct packed {
        t_chan channel;
        t_sum  window_sum;
        logic  end_of_scan;
    } t_window_result;

    // scan order packed four bits per slot, slot 0 in the low nibble;
    // slots past the scan map to themselves and are out of range
    localparam logic [63:0] SLOT_CHANNEL = {4'd15, 4'd14, 4'd13, 4'd6, 4'd9, 4'd5, 4'd8, 4'd4,
                                            4'd11, 4'd7, 4'd10, 4'd3, 4'd1, 4'd2, 4'd0, 4'd12};

    t_sample        history [NUM_CHANNELS][WINDOW_DEPTH];
    int             chan_total [NUM_CHANNELS];
    t_pos           scan_pos;
    t_window_result sums_due [$];
    int             errors = 0;

    function automatic t_window_result accumulate(t_chan ch, t_slot slot, t_sample smp);
        t_window_result res;
        int             total;
        total = chan_total[ch] + int'(smp) - int'(history[ch][scan_pos]);
        if (total < 0)
            total = 0;
        chan_total[ch]         = total;
        history[ch][scan_pos]  = smp;
        res.channel     = ch;
        res.window_sum  = t_sum'(total);
        res.end_of_scan = (int'(slot) == LAST_SLOT);
        if (res.end_of_scan)
            scan_pos = (int'(scan_pos) == WINDOW_DEPTH - 1) ? '0 : scan_pos + t_pos'(1);
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_window_result want;
        t_chan          ch;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                chan_total[c] = 0;
                for (int p = 0; p < WINDOW_DEPTH; p++)
                    history[c][p] = '0;
            end
            scan_pos = '0;
            sums_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sums_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat: expected none, %s %0d sum %0d",
                             $time, "got channel", i_out_channel, i_out_sum);
                end else begin
                    want = sums_due.pop_front();
                    if (i_out_channel !== want.channel) begin
                        errors++;
                        $display("%0t: channel: expected %0d, got %0d",
                                 $time, want.channel, i_out_channel);
                    end
                    if (i_out_sum !== want.window_sum) begin
                        errors++;
                        $display("%0t: window_sum (ch %0d): expected %0d, got %0d",
                                 $time, want.channel, want.window_sum, i_out_sum);
                    end
                    if (i_out_eos !== want.end_of_scan) begin
                        errors++;
                        $display("%0t: end_of_scan (ch %0d): expected %0b, got %0b",
                                 $time, want.channel, want.end_of_scan, i_out_eos);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ch = SLOT_CHANNEL[i_in_slot*4 +: 4];
                if (int'(i_in_slot) < NUM_CHANNELS && int'(ch) < NUM_CHANNELS)
                    sums_due.push_back(accumulate(ch, i_in_slot, i_in_sample));
            end
        end
        o_error_count <= errors;
        o_pending     <= sums_due.size();
    end

endmodule

>>> bench/tb_multichannel_moving_window_sum.sv
`timescale 1ns / 100ps
// Testbench top for multichannel_moving_window_sum: clock, reset, sample stimulus
// and result-side stalls. Depends on mmws_pkg and mmws_sum_checker.
module tb_multichannel_moving_window_sum;
    import mmws_pkg::*;

    localparam int TOTAL_BEATS    = 1100;
    localparam int FULL_RUN_SCANS = 130;
    localparam int LONG_HOLD      = 64;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum int {DATA_RANDOM, DATA_FULL, DATA_ZERO, DATA_LOW} t_data_mode;
    typedef enum int {SCAN_FULL, SCAN_SHORT, SCAN_REPEAT, SCAN_NOISE} t_scan_kind;

    logic    i_clk;
    logic    i_rst_n     = 1'b0;
    logic    i_valid     = 1'b0;
    logic    o_stall;
    t_slot   i_scan_slot = '0;
    t_sample i_sample    = '0;
    logic    o_valid;
    logic    i_stall     = 1'b0;
    t_chan   o_channel;
    t_sum    o_window_sum;
    logic    o_end_of_scan;

    int error_count;
    int pending;
    int beats_sent   = 0;
    int cycle_count  = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit rx_long_hold = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    multichannel_moving_window_sum uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_scan_slot   (i_scan_slot),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_channel     (o_channel),
        .o_window_sum  (o_window_sum),
        .o_end_of_scan (o_end_of_scan)
    );

    mmws_sum_checker u_sum_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_slot     (i_scan_slot),
        .i_in_sample   (i_sample),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_channel (o_channel),
        .i_out_sum     (o_window_sum),
        .i_out_eos     (o_end_of_scan),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    function automatic t_sample draw_sample(t_data_mode mode);
        unique case (mode)
            DATA_FULL: return '1;
            DATA_ZERO: return '0;
            DATA_LOW:  return t_sample'($urandom_range(0, 7));
            default:   return t_sample'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
        endcase
    endfunction

    task automatic send_beat(input t_slot slot, input t_sample smp);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_scan_slot <= slot;
        i_sample    <= smp;
        do @(posedge i_clk); while (o_stall);
        if (int'(slot) < NUM_CHANNELS)
            beats_sent++;
    endtask

    task automatic send_scan(input t_scan_kind kind, input t_data_mode mode);
        int n;
        int dup;
        unique case (kind)
            SCAN_FULL: begin
                for (int s = 0; s < NUM_CHANNELS; s++)
                    send_beat(t_slot'(s), draw_sample(mode));
            end
            SCAN_SHORT: begin
                // up to four early slots, then the closing slot to step the window
                n = $urandom_range(0, 4);
                repeat (n) send_beat(t_slot'($urandom_range(0, LAST_SLOT - 1)), draw_sample(mode));
                send_beat(t_slot'(LAST_SLOT), draw_sample(mode));
            end
            SCAN_REPEAT: begin
                dup = $urandom_range(0, LAST_SLOT);
                for (int s = 0; s < NUM_CHANNELS; s++) begin
                    send_beat(t_slot'(s), draw_sample(mode));
                    if (s == dup)
                        send_beat(t_slot'(s), draw_sample(mode));
                end
            end
            default: begin
                n = $urandom_range(1, 4);
                repeat (n) send_beat(t_slot'($urandom_range(0, (1 << SLOT_BITS) - 1)),
                                     t_sample'($urandom));
            end
        endcase
    endtask

    initial begin : stimulus
        int         pick;
        t_scan_kind kind;
        t_data_mode mode;
        bit         held;
        bit         paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < NUM_CHANNELS; s++)
            send_beat(t_slot'(s), '1);
        send_beat(t_slot'(NUM_CHANNELS), '1);
        send_beat(t_slot'(NUM_CHANNELS + 1), '0);
        send_beat('1, t_sample'($urandom));
        send_beat(t_slot'(4), t_sample'(10'h155));
        send_beat(t_slot'(4), t_sample'(10'h2AA));
        send_beat(t_slot'(LAST_SLOT), '0);

        // closing slot alone at full scale for more than a window: that channel
        // reaches its top sum and the window position wraps
        tx_steady = 1'b1;
        repeat (FULL_RUN_SCANS) send_beat(t_slot'(LAST_SLOT), '1);
        tx_steady = 1'b0;

        while (beats_sent < TOTAL_BEATS) begin
            if (!held && beats_sent > 400) begin
                held         = 1'b1;
                rx_long_hold = 1'b1;
            end
            if (!paused && beats_sent > 700) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if ($urandom_range(0, 7) == 0)
                tx_steady = !tx_steady;
            pick = $urandom_range(0, 9);
            kind = (pick < 5) ? SCAN_FULL : (pick < 8) ? SCAN_SHORT :
                   (pick < 9) ? SCAN_REPEAT : SCAN_NOISE;
            pick = $urandom_range(0, 9);
            mode = (pick < 7) ? DATA_RANDOM : (pick < 8) ? DATA_FULL :
                   (pick < 9) ? DATA_ZERO : DATA_LOW;
            send_scan(kind, mode);
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : result_side
        int hold;
        @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if ($urandom_range(0, 15) == 0)
                rx_steady = !rx_steady;
            hold = rx_steady ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
